### hdl/dmwbc_pkg.sv
package dmwbc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned COST_W = 16;
   localparam int unsigned CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] CSR_MEM_READ    = 2'd0;
   localparam logic [1:0] CSR_MEM_WRITE   = 2'd1;
   localparam logic [1:0] CSR_CACHE_READ  = 2'd2;
   localparam logic [1:0] CSR_CACHE_WRITE = 2'd3;

   localparam logic [COST_W-1:0] MEM_READ_COST_RST    = 16'd100;
   localparam logic [COST_W-1:0] MEM_WRITE_COST_RST   = 16'd50;
   localparam logic [COST_W-1:0] CACHE_READ_COST_RST  = 16'd1;
   localparam logic [COST_W-1:0] CACHE_WRITE_COST_RST = 16'd1;

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b0000000001,
      ST_IDLE    = 10'b0000000010,
      ST_LOOKUP  = 10'b0000000100,
      ST_WB_RD   = 10'b0000001000,
      ST_WB_WR   = 10'b0000010000,
      ST_FILL_RD = 10'b0000100000,
      ST_FILL_WR = 10'b0001000000,
      ST_ACCESS  = 10'b0010000000,
      ST_RDWAIT  = 10'b0100000000,
      ST_RESP    = 10'b1000000000
   } state_type;

endpackage

### hdl/dmwbc_ram.sv
module dmwbc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/direct_mapped_writeback_cache.sv
// Channel   Direction  Ports                                  Handshake
// request   in         req_command, req_address, req_write_data  start / busy
// response  out        rsp_read_data, rsp_hit, rsp_error,     rsp_strobe, one cycle
//                      rsp_elapsed_time
// csr       in         csr_index, csr_data                    csr_valid / csr_ready
//
// One word is taken at a time. On a read hit the tag store is read as the word
// is accepted, the tag is compared, the data store is read through its
// registered port, then the response is registered. A write hit writes the word
// and marks the line dirty in place of the data read. Busy stays high in the
// response cycle, so the next word is taken in the cycle after the response at
// the earliest. A miss adds a refill of the line, a read and a write step per
// word, and, when the victim line is dirty, a write-back before it, also a read
// and a write step per word. Every memory port has a registered read.
// After reset a clearing pass runs over the backing memory and the tag store,
// one word a cycle over MEMORY_BYTES/4 words (at least LINES); busy stays high
// throughout. Configuration writes are taken at any time outside reset. The
// receiver cannot stall: each response is shown for exactly one cycle.
module direct_mapped_writeback_cache
   import dmwbc_pkg::*;
#(
   parameter int unsigned LINES          = 256,
   parameter int unsigned WORDS_PER_LINE = 16,
   parameter int unsigned MEMORY_BYTES   = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [DATA_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_strobe,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_hit,
   output logic              rsp_error,
   output logic [DATA_W-1:0] rsp_elapsed_time,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [DATA_W-1:0] csr_data
);

   localparam int unsigned MEM_WORDS   = MEMORY_BYTES / 4;
   localparam int unsigned CACHE_WORDS = LINES * WORDS_PER_LINE;
   localparam int unsigned OFF_W   = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
   localparam int unsigned IDX_W   = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int unsigned CW_W    = (CACHE_WORDS > 1) ? $clog2(CACHE_WORDS) : 1;
   localparam int unsigned MW_W    = $clog2(MEM_WORDS);
   // Word address width: a line base may run past memory by up to a line.
   localparam int unsigned WA_W    = $clog2(MEM_WORDS + WORDS_PER_LINE);
   localparam int unsigned LNUM_W  = WA_W - $clog2(WORDS_PER_LINE);
   localparam int unsigned TAG_W   = (LNUM_W > $clog2(LINES)) ? LNUM_W - $clog2(LINES) : 1;
   localparam int unsigned TAGE_W  = TAG_W + 2;   // valid, dirty, tag
   localparam int unsigned CLR_N   = (MEM_WORDS > LINES) ? MEM_WORDS : LINES;
   localparam int unsigned CLR_W   = $clog2(CLR_N + 1);

   state_type state_ff, state_in;

   logic [COST_W-1:0] mrc_ff, mwc_ff, crc_ff, cwc_ff;
   logic [DATA_W-1:0] time_ff, time_in;

   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [WA_W-1:0]   word_ff, word_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [OFF_W:0]    cnt_ff, cnt_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic              hit_ff, hit_in;
   logic [TAG_W-1:0]  vtag_ff, vtag_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic              rsp_hit_ff, rsp_hit_in, rsp_err_ff, rsp_err_in;

   // Memory ports.
   logic              tag_we;
   logic [IDX_W-1:0]  tag_waddr, tag_raddr;
   logic [TAGE_W-1:0] tag_wdata, tag_rdata;
   logic              dat_we;
   logic [CW_W-1:0]   dat_waddr, dat_raddr;
   logic [DATA_W-1:0] dat_wdata, dat_rdata;
   logic              mem_we;
   logic [MW_W-1:0]   mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata, mem_rdata;

   dmwbc_ram #(.WIDTH(TAGE_W), .DEPTH(LINES)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_wdata),
      .rd_addr(tag_raddr), .rd_data(tag_rdata));
   dmwbc_ram #(.WIDTH(DATA_W), .DEPTH(CACHE_WORDS)) u_data_ram (
      .clock(clock), .wr_en(dat_we), .wr_addr(dat_waddr), .wr_data(dat_wdata),
      .rd_addr(dat_raddr), .rd_data(dat_rdata));
   dmwbc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_back_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata));

   // Address fields of the current word.
   logic [OFF_W-1:0] off;
   logic [IDX_W-1:0] idx;
   logic [TAG_W-1:0] tag;
   logic [WA_W-1:0]  lnum;
   logic             t_valid, t_dirty;
   logic [TAG_W-1:0] t_tag;
   logic [WA_W-1:0]  old_base, new_base, mem_word;
   logic [OFF_W-1:0] cnt_off;
   logic [OFF_W-1:0] prev_off;
   // Line index of the word on the request ports, so the tag store is read as it is taken.
   logic [WA_W-1:0]  req_word;
   logic [IDX_W-1:0] req_idx;

   always_comb begin
      lnum     = word_ff / WA_W'(WORDS_PER_LINE);
      off      = OFF_W'(word_ff % WA_W'(WORDS_PER_LINE));
      idx      = IDX_W'(lnum % WA_W'(LINES));
      tag      = TAG_W'(lnum / WA_W'(LINES));
      t_valid  = tag_rdata[TAGE_W-1];
      t_dirty  = tag_rdata[TAGE_W-2];
      t_tag    = tag_rdata[TAG_W-1:0];
      cnt_off  = OFF_W'(cnt_ff);
      prev_off = OFF_W'(cnt_ff - 1'b1);
      old_base = WA_W'((WA_W'(vtag_ff) * WA_W'(LINES) + WA_W'(idx)) * WA_W'(WORDS_PER_LINE));
      new_base = WA_W'(lnum * WA_W'(WORDS_PER_LINE));
      req_word = WA_W'(req_address[DATA_W-1:2]);
      req_idx  = IDX_W'((req_word / WA_W'(WORDS_PER_LINE)) % WA_W'(LINES));
   end

   logic [CW_W-1:0] line_base;
   assign line_base = CW_W'(CW_W'(idx) * CW_W'(WORDS_PER_LINE));

   // The range check of the fill read address is registered so it lines up with data.
   logic             fill_oob_ff, fill_oob_in;

   always_comb begin
      state_in      = state_ff;
      time_in       = time_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      wdata_in      = wdata_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      hit_in        = hit_ff;
      vtag_in       = vtag_ff;
      fill_oob_in   = fill_oob_ff;
      rsp_strobe_in = 1'b0;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_err_in    = rsp_err_ff;
      mem_word      = '0;
      tag_we = 1'b0; tag_waddr = idx; tag_wdata = '0; tag_raddr = idx;
      dat_we = 1'b0; dat_waddr = line_base + CW_W'(off); dat_wdata = wdata_ff;
      dat_raddr = line_base + CW_W'(off);
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = dat_rdata; mem_raddr = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = MW_W'(clr_ff);
            mem_wdata = '0;
            tag_we    = 1'b1;
            tag_waddr = IDX_W'(clr_ff);
            tag_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            tag_raddr = req_idx;
            if (start) begin
               cmd_in   = req_command;
               word_in  = req_word;
               wdata_in = req_write_data;
               rsp_hit_in   = 1'b0;
               rsp_err_in   = 1'b0;
               rsp_rdata_in = '0;
               if (req_command == CMD_CLEAR) begin
                  time_in       = '0;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_RESP;
               end else if (req_command != CMD_READ && req_command != CMD_WRITE) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_RESP;
               end else if (req_address[DATA_W-1:2] >= (DATA_W-2)'(MEM_WORDS)) begin
                  rsp_err_in    = 1'b1;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            // Tag entry for idx is on tag_rdata now.
            vtag_in = t_tag;
            cnt_in  = '0;
            if (t_valid && t_tag == tag) begin
               hit_in   = 1'b1;
               state_in = ST_ACCESS;
            end else begin
               hit_in  = 1'b0;
               time_in = time_ff + DATA_W'(mrc_ff);
               if (t_valid && t_dirty) begin
                  time_in  = time_ff + DATA_W'(mrc_ff) + DATA_W'(mwc_ff);
                  state_in = ST_WB_RD;
               end else begin
                  state_in = ST_FILL_RD;
               end
            end
         end
         ST_WB_RD: begin
            dat_raddr = line_base + CW_W'(cnt_off);
            state_in  = ST_WB_WR;
         end
         ST_WB_WR: begin
            mem_word  = old_base + WA_W'(cnt_off);
            mem_we    = (mem_word < WA_W'(MEM_WORDS));
            mem_waddr = MW_W'(mem_word);
            mem_wdata = dat_rdata;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == (OFF_W+1)'(WORDS_PER_LINE - 1)) begin
               cnt_in   = '0;
               state_in = ST_FILL_RD;
            end else begin
               state_in = ST_WB_RD;
            end
         end
         ST_FILL_RD: begin
            mem_word    = new_base + WA_W'(cnt_off);
            mem_raddr   = MW_W'(mem_word);
            fill_oob_in = (mem_word >= WA_W'(MEM_WORDS));
            cnt_in      = cnt_ff + 1'b1;
            state_in    = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            dat_we    = 1'b1;
            dat_waddr = line_base + CW_W'(prev_off);
            dat_wdata = fill_oob_ff ? '0 : mem_rdata;
            if (cnt_ff == (OFF_W+1)'(WORDS_PER_LINE)) begin
               tag_we    = 1'b1;
               tag_wdata = {1'b1, 1'b0, tag};
               state_in  = ST_ACCESS;
            end else begin
               state_in = ST_FILL_RD;
            end
         end
         ST_ACCESS: begin
            // Word access; on a write, mark the line dirty.
            if (cmd_ff == CMD_WRITE) begin
               dat_we    = 1'b1;
               tag_we    = 1'b1;
               tag_wdata = {1'b1, 1'b1, tag};
               time_in   = time_ff + DATA_W'(cwc_ff);
               rsp_rdata_in  = '0;
               rsp_hit_in    = hit_ff;
               rsp_strobe_in = 1'b1;
               state_in      = ST_RESP;
            end else begin
               time_in  = time_ff + DATA_W'(crc_ff);
               state_in = ST_RDWAIT;
            end
         end
         ST_RDWAIT: begin
            rsp_rdata_in  = dat_rdata;
            rsp_hit_in    = hit_ff;
            rsp_strobe_in = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         time_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         mrc_ff <= MEM_READ_COST_RST;
         mwc_ff <= MEM_WRITE_COST_RST;
         crc_ff <= CACHE_READ_COST_RST;
         cwc_ff <= CACHE_WRITE_COST_RST;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         time_ff       <= time_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MEM_READ:    mrc_ff <= csr_data[COST_W-1:0];
               CSR_MEM_WRITE:   mwc_ff <= csr_data[COST_W-1:0];
               CSR_CACHE_READ:  crc_ff <= csr_data[COST_W-1:0];
               CSR_CACHE_WRITE: cwc_ff <= csr_data[COST_W-1:0];
               default: ;
            endcase
         end
      end
      cmd_ff       <= cmd_in;
      word_ff      <= word_in;
      wdata_ff     <= wdata_in;
      cnt_ff       <= cnt_in;
      hit_ff       <= hit_in;
      vtag_ff      <= vtag_in;
      fill_oob_ff  <= fill_oob_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // The counter value seen with a response is the one after that item.
   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = !reset;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_data    = rsp_rdata_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_error        = rsp_err_ff;
   assign rsp_elapsed_time = time_ff;

   a_strobe_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ST_RESP) else $error("strobe outside response state");
   a_err_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_error |-> !rsp_hit && rsp_read_data == '0)
      else $error("error response carries data");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held longer than one cycle");
   a_fill_writes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL_WR |-> dat_we) else $error("fill step without data write");

endmodule

### tb/testbench.sv
module testbench
   import dmwbc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINES          = 256;
   localparam int unsigned WORDS_PER_LINE = 16;
   localparam int unsigned MEMORY_BYTES   = 65536;
   localparam int unsigned MEM_WORDS      = MEMORY_BYTES / 4;
   localparam int unsigned CYCLE_LIMIT    = 1200000;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;

   // One expected response word.
   typedef struct {
      logic [DATA_W-1:0] read_data;
      logic              hit;
      logic              error;
      logic [DATA_W-1:0] elapsed_time;
   } response_type;

   int unsigned mismatch_count = 0;

   // Every mismatch is reported here as one line and counted.
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] seen,
                                  input logic [DATA_W-1:0] wanted);
      mismatch_count++;
      $display("mismatch on %s: got %h, expected %h at %0t", what, seen, wanted, $realtime);
   endtask

   // The scoreboard holds its own copy of the cache, the backing memory and
   // the cost counter, and queues one expected response per accepted word.
   class cache_scoreboard;
      logic [COST_W-1:0] costs [4];
      logic [17:0]       tags [LINES];
      logic              valid [LINES];
      logic              dirty [LINES];
      logic [DATA_W-1:0] words [LINES*WORDS_PER_LINE];
      logic [DATA_W-1:0] memory [MEM_WORDS];
      logic [DATA_W-1:0] counter;
      response_type      pending [$];

      function new();
         costs[CSR_MEM_READ]    = MEM_READ_COST_RST;
         costs[CSR_MEM_WRITE]   = MEM_WRITE_COST_RST;
         costs[CSR_CACHE_READ]  = CACHE_READ_COST_RST;
         costs[CSR_CACHE_WRITE] = CACHE_WRITE_COST_RST;
         foreach (tags[i]) begin
            tags[i] = '0;
            valid[i] = 1'b0;
            dirty[i] = 1'b0;
         end
         foreach (words[i]) words[i] = '0;
         foreach (memory[i]) memory[i] = '0;
         counter = '0;
      endfunction

      function void set_cost(input logic [1:0] index, input logic [DATA_W-1:0] value);
         costs[index] = value[COST_W-1:0];
      endfunction

      function void note_request(input logic [1:0] command, input logic [DATA_W-1:0] address,
                                 input logic [DATA_W-1:0] data);
         response_type r;
         logic [31:0] word, line_number, index, tag, base, old_base;
         r.read_data = '0;
         r.hit = 1'b0;
         r.error = 1'b0;
         if (command == CMD_CLEAR) begin
            counter = '0;
         end else if (command == CMD_READ || command == CMD_WRITE) begin
            word = address >> 2;
            if (word >= MEM_WORDS) begin
               r.error = 1'b1;
            end else begin
               line_number = word / WORDS_PER_LINE;
               index = line_number % LINES;
               tag = line_number / LINES;
               base = index * WORDS_PER_LINE;
               if (valid[index] && tags[index] == tag[17:0]) begin
                  r.hit = 1'b1;
               end else begin
                  counter += costs[CSR_MEM_READ];
                  // A dirty victim goes back to memory before the refill.
                  if (valid[index] && dirty[index]) begin
                     old_base = (tags[index] * LINES + index) * WORDS_PER_LINE;
                     for (int i = 0; i < WORDS_PER_LINE; i++)
                        if (old_base + i < MEM_WORDS) memory[old_base + i] = words[base + i];
                     counter += costs[CSR_MEM_WRITE];
                  end
                  for (int i = 0; i < WORDS_PER_LINE; i++)
                     words[base + i] = (line_number * WORDS_PER_LINE + i < MEM_WORDS) ?
                                       memory[line_number * WORDS_PER_LINE + i] : '0;
                  valid[index] = 1'b1;
                  tags[index] = tag[17:0];
                  dirty[index] = 1'b0;
               end
               if (command == CMD_READ) begin
                  r.read_data = words[base + word % WORDS_PER_LINE];
                  counter += costs[CSR_CACHE_READ];
               end else begin
                  words[base + word % WORDS_PER_LINE] = data;
                  counter += costs[CSR_CACHE_WRITE];
                  dirty[index] = 1'b1;
               end
            end
         end
         r.elapsed_time = counter;
         pending.push_back(r);
      endfunction

      task check_response(input logic [DATA_W-1:0] read_data, input logic hit,
                          input logic error, input logic [DATA_W-1:0] elapsed_time);
         response_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", read_data, '0);
            return;
         end
         e = pending.pop_front();
         if (read_data !== e.read_data) report_mismatch("read_data", read_data, e.read_data);
         if (hit !== e.hit) report_mismatch("hit", DATA_W'(hit), DATA_W'(e.hit));
         if (error !== e.error) report_mismatch("error", DATA_W'(error), DATA_W'(e.error));
         if (elapsed_time !== e.elapsed_time)
            report_mismatch("elapsed_time", elapsed_time, e.elapsed_time);
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_command = '0;
   logic [DATA_W-1:0] req_address = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_strobe;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_hit;
   logic              rsp_error;
   logic [DATA_W-1:0] rsp_elapsed_time;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   cache_scoreboard   board = new();
   int unsigned       cycle_count = 0;

   direct_mapped_writeback_cache #(
      .LINES(LINES), .WORDS_PER_LINE(WORDS_PER_LINE), .MEMORY_BYTES(MEMORY_BYTES)
   ) i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Responses cannot be held off, so each strobe is checked at the edge
   // that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_response(rsp_read_data, rsp_hit, rsp_error, rsp_elapsed_time);
   end

   // The watchdog allows for the clearing pass after reset, a dirty miss on
   // every word and the longest idle gaps, several times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one, and often none at all.
   task automatic idle_gap();
      int unsigned n;
      n = ($urandom_range(0, 9) < 4) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (n) @(posedge clock);
   endtask

   // Presents one word and holds it until the block has taken it. Start drops
   // afterwards; the block is busy then in any case.
   task automatic send_request(input logic [1:0] command, input logic [DATA_W-1:0] address,
                               input logic [DATA_W-1:0] data);
      start <= 1'b1;
      req_command <= command;
      req_address <= address;
      req_write_data <= data;
      do @(posedge clock); while (busy);
      board.note_request(command, address, data);
      start <= 1'b0;
      @(posedge clock);
      idle_gap();
   endtask

   task automatic write_cost(input logic [1:0] index, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_cost(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected response has come back, then lets the block settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Most addresses are drawn from a few line indexes with a few tags each, so that
   // hits, clean misses and dirty write-backs all come up often.
   function automatic logic [DATA_W-1:0] pick_address();
      logic [DATA_W-1:0] a;
      case ($urandom_range(0, 19))
         0: a = $urandom();
         1: a = MEMORY_BYTES + $urandom_range(0, 4096);
         2: a = MEMORY_BYTES - 4 + $urandom_range(0, 3);
         default: a = ($urandom_range(0, 3) << 14) | ($urandom_range(0, 7) << 6)
                      | ($urandom_range(0, 15) << 2) | $urandom_range(0, 3);
      endcase
      return a;
   endfunction

   function automatic logic [1:0] pick_command();
      int unsigned r;
      r = $urandom_range(0, 99);
      return (r < 45) ? CMD_READ : (r < 90) ? CMD_WRITE : (r < 96) ? CMD_CLEAR : CMD_UNUSED;
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, each command, out-of-range words, the
      // unused command, a dirty write-back and its reload.
      send_request(CMD_READ, 32'h0000_0000, 32'h0);
      send_request(CMD_WRITE, 32'h0000_0003, 32'hFFFF_FFFF);
      send_request(CMD_READ, 32'h0000_0001, 32'h0);
      send_request(CMD_WRITE, MEMORY_BYTES - 1, 32'hA5A5_5A5A);
      send_request(CMD_READ, MEMORY_BYTES - 4, 32'h0);
      send_request(CMD_READ, MEMORY_BYTES, 32'h0);
      send_request(CMD_WRITE, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(CMD_UNUSED, 32'h0000_0010, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, 32'h0000_4000, 32'h0BAD_F00D);
      send_request(CMD_READ, 32'h0000_0000, 32'h0);
      send_request(CMD_READ, 32'h0000_4000, 32'h0);
      send_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_READ, MEMORY_BYTES - 4, 32'h0);
      drain();

      // Random phases, each under its own cost setting, the extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         for (int k = 0; k < 4; k++)
            write_cost(k[1:0], (phase == 0) ? 32'h0 : (phase == 1) ? 32'hFFFF_FFFF :
                       (phase == 2) ? 32'h0000_FFFF : $urandom());
         for (int n = 0; n < 158; n++)
            send_request(pick_command(), pick_address(), $urandom());
         drain();
      end

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/dmwbc_pkg.sv
hdl/dmwbc_ram.sv
hdl/direct_mapped_writeback_cache.sv
tb/testbench.sv
